[hw/rtl/aawf_pkg.sv]
`timescale 1ns / 1ps

package aawf_pkg;

  // Datapath word and derived widths
  localparam int WordBits = 16;
  localparam int ByteBits = 8;
  localparam int CntBits  = $clog2(WordBits);
  localparam int StepBits = $clog2(WordBits + 1);

  typedef logic [WordBits-1:0] word_t;
  typedef logic [StepBits-1:0] step_t;

  // Operation codes
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_REM  = 4'd4,
    OP_AND  = 4'd5,
    OP_OR   = 4'd6,
    OP_XOR  = 4'd7,
    OP_NOT  = 4'd8,
    OP_SHL  = 4'd9,
    OP_SHR  = 4'd10,
    OP_ROL  = 4'd11,
    OP_ROR  = 4'd12,
    OP_CMP  = 4'd13,
    OP_LOAD = 4'd14
  } op_e;

  // Flag register, bit 0 zero up to bit 3 overflow
  typedef struct packed {
    logic ovf;
    logic sign;
    logic carry;
    logic zero;
  } flags_t;

  // Microprogram addresses
  localparam int PcBits = 3;
  typedef logic [PcBits-1:0] pc_t;

  localparam pc_t PcFetch   = 3'd0;
  localparam pc_t PcDecode  = 3'd1;
  localparam pc_t PcExec    = 3'd2;
  localparam pc_t PcSpare   = 3'd3;
  localparam pc_t PcDivInit = 3'd4;
  localparam pc_t PcDivStep = 3'd5;
  localparam pc_t PcDivFin  = 3'd6;
  localparam pc_t PcOut     = 3'd7;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_INPUT = 3'd2,
    COND_DIV      = 3'd3,
    COND_DIV_MORE = 3'd4,
    COND_OUT_BUSY = 3'd5
  } cond_e;

  // One control word
  typedef struct packed {
    logic  in_rdy;
    logic  alu_exec;
    logic  div_init;
    logic  div_step;
    logic  div_fin;
    logic  out_push;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_div;
    logic div_more;
    logic out_busy;
  } stat_t;

  // Control store
  function automatic ctrl_t ucode_rom(pc_t pc);
    ctrl_t c;
    c        = '0;
    c.cond   = COND_NEVER;
    c.target = PcFetch;
    unique case (pc)
      PcFetch: begin
        c.in_rdy = 1'b1;
        c.cond   = COND_NO_INPUT;
        c.target = PcFetch;
      end
      PcDecode: begin
        c.cond   = COND_DIV;
        c.target = PcDivInit;
      end
      PcExec: begin
        c.alu_exec = 1'b1;
        c.cond     = COND_ALWAYS;
        c.target   = PcOut;
      end
      PcSpare: begin
        c.cond   = COND_ALWAYS;
        c.target = PcFetch;
      end
      PcDivInit: begin
        c.div_init = 1'b1;
      end
      PcDivStep: begin
        c.div_step = 1'b1;
        c.cond     = COND_DIV_MORE;
        c.target   = PcDivStep;
      end
      PcDivFin: begin
        c.div_fin = 1'b1;
      end
      PcOut: begin
        // falls through to fetch by address wrap
        c.out_push = 1'b1;
        c.cond     = COND_OUT_BUSY;
        c.target   = PcOut;
      end
    endcase
    return c;
  endfunction

  // Zero and sign follow the result
  function automatic flags_t zs_flags(word_t r);
    flags_t f;
    f      = '0;
    f.zero = (r == '0);
    f.sign = r[WordBits-1];
    return f;
  endfunction

  // Add-style carry and overflow
  function automatic flags_t add_rule(word_t r, word_t a, word_t b);
    flags_t f;
    word_t  t;
    f       = zs_flags(r);
    t       = (a ^ r) & (b ^ r);
    f.carry = (r < a) || (r < b);
    f.ovf   = t[WordBits-1];
    return f;
  endfunction

endpackage

[hw/rtl/accumulator_alu_with_flags_core.sv]
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// in       in_valid_i/in_ready_o   op_i, operand_i, byte_mode_i
// out      out_valid_o/out_ready_i acc_out_o, zero/carry/sign/overflow_flag_o,
//                                  divide_error_o
//
// A microprogram steps fetch, decode, execute, output. Div and rem with a
// nonzero divisor go through the radix-2 divider instead of execute, one
// quotient bit per step over 16 steps.
// Reset clears accumulator, flags and step counter; no clearing pass.
// A result waiting in the output register does not block the next fetch; the
// output step stalls only when that register is still full.
module accumulator_alu_with_flags_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  op_i,
  input  logic [15:0] operand_i,
  input  logic        byte_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] acc_out_o,
  output logic        zero_flag_o,
  output logic        carry_flag_o,
  output logic        sign_flag_o,
  output logic        overflow_flag_o,
  output logic        divide_error_o
);

  aawf_pkg::ctrl_t ctrl;
  aawf_pkg::stat_t stat;

  aawf_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  aawf_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .in_valid_i      (in_valid_i),
    .op_i            (op_i),
    .operand_i       (operand_i),
    .byte_mode_i     (byte_mode_i),
    .out_ready_i     (out_ready_i),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .acc_out_o       (acc_out_o),
    .zero_flag_o     (zero_flag_o),
    .carry_flag_o    (carry_flag_o),
    .sign_flag_o     (sign_flag_o),
    .overflow_flag_o (overflow_flag_o),
    .divide_error_o  (divide_error_o)
  );

  assign in_ready_o = ctrl.in_rdy;

`ifndef SYNTH
  // One item in flight: no fetch right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while previous item in flight");

  // Divide finish only after the last divider step
  a_div_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.div_fin |-> $past(ctrl.div_step))
    else $error("divide finish without preceding step");

  // Output step waiting on a full register must not overwrite it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.out_push && stat.out_busy) |=> (out_valid_o && $stable(acc_out_o)
      && $stable(divide_error_o)))
    else $error("result register overwritten while full");
`endif

endmodule

[hw/rtl/aawf_div.sv]
`timescale 1ns / 1ps

// Restoring radix-2 divider, one quotient bit per step
module aawf_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    init_i,
  input  logic                    step_i,
  input  aawf_pkg::word_t         dividend_i,
  input  aawf_pkg::word_t         divisor_i,
  output aawf_pkg::word_t         quo_o,
  output aawf_pkg::word_t         rem_o,
  output logic                    more_o
);

  aawf_pkg::word_t quo_q, quo_d;
  aawf_pkg::word_t rem_q, rem_d;
  aawf_pkg::step_t cnt_q, cnt_d;

  logic [aawf_pkg::WordBits:0] shifted;
  logic [aawf_pkg::WordBits:0] diff;

  // Trial subtract
  always_comb begin
    shifted = {rem_q, quo_q[aawf_pkg::WordBits-1]};
    diff    = shifted - {1'b0, divisor_i};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    if (init_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = aawf_pkg::step_t'(aawf_pkg::WordBits);
    end else if (step_i) begin
      cnt_d = cnt_q - aawf_pkg::step_t'(1);
      if (!diff[aawf_pkg::WordBits]) begin
        rem_d = diff[aawf_pkg::WordBits-1:0];
        quo_d = {quo_q[aawf_pkg::WordBits-2:0], 1'b1};
      end else begin
        rem_d = shifted[aawf_pkg::WordBits-1:0];
        quo_d = {quo_q[aawf_pkg::WordBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // More steps remain after the current one
  assign more_o = (cnt_q != aawf_pkg::step_t'(1));
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/aawf_useq.sv]
`timescale 1ns / 1ps

// Step counter, control store and jump logic
module aawf_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  aawf_pkg::stat_t stat_i,
  output aawf_pkg::ctrl_t ctrl_o
);

  aawf_pkg::pc_t   pc_q, pc_d;
  aawf_pkg::ctrl_t ctrl;
  logic            take;

  assign ctrl = aawf_pkg::ucode_rom(pc_q);

  // Jump condition
  always_comb begin
    unique case (ctrl.cond)
      aawf_pkg::COND_NEVER:    take = 1'b0;
      aawf_pkg::COND_ALWAYS:   take = 1'b1;
      aawf_pkg::COND_NO_INPUT: take = !stat_i.in_valid;
      aawf_pkg::COND_DIV:      take = stat_i.is_div;
      aawf_pkg::COND_DIV_MORE: take = stat_i.div_more;
      aawf_pkg::COND_OUT_BUSY: take = stat_i.out_busy;
      default:                 take = 1'b0;
    endcase
    pc_d = take ? ctrl.target : pc_q + aawf_pkg::pc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= aawf_pkg::PcFetch;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

[hw/rtl/aawf_dpath.sv]
`timescale 1ns / 1ps

// Item registers, accumulator, flags, ALU, divider and result register
module aawf_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  aawf_pkg::ctrl_t ctrl_i,
  input  logic            in_valid_i,
  input  logic [3:0]      op_i,
  input  logic [15:0]     operand_i,
  input  logic            byte_mode_i,
  input  logic            out_ready_i,
  output aawf_pkg::stat_t stat_o,
  output logic            out_valid_o,
  output logic [15:0]     acc_out_o,
  output logic            zero_flag_o,
  output logic            carry_flag_o,
  output logic            sign_flag_o,
  output logic            overflow_flag_o,
  output logic            divide_error_o
);

  localparam int W = aawf_pkg::WordBits;

  // Latched item
  logic [3:0]      op_q;
  aawf_pkg::word_t b_q;
  logic            bm_q;

  // Architectural state
  aawf_pkg::word_t  acc_q;
  aawf_pkg::flags_t flags_q;
  logic             derr_q;

  // Result register
  logic             out_valid_q;
  aawf_pkg::word_t  out_acc_q;
  aawf_pkg::flags_t out_flags_q;
  logic             out_derr_q;

  aawf_pkg::word_t  r_exec;
  aawf_pkg::flags_t f_exec;
  logic             derr_exec;
  aawf_pkg::word_t  quo, rem, r_div;
  logic             div_more;
  logic             take_in;
  logic             out_busy;
  logic             push;
  logic             is_divop;

  assign take_in  = ctrl_i.in_rdy && in_valid_i;
  assign out_busy = out_valid_q && !out_ready_i;
  assign push     = ctrl_i.out_push && !out_busy;
  assign is_divop = (op_q == aawf_pkg::OP_DIV) || (op_q == aawf_pkg::OP_REM);

  // Item latch, operand masked in byte mode
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      op_q <= op_i;
      b_q  <= byte_mode_i ? aawf_pkg::word_t'(operand_i[aawf_pkg::ByteBits-1:0])
                          : aawf_pkg::word_t'(operand_i);
      bm_q <= byte_mode_i;
    end
  end

  aawf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (ctrl_i.div_init),
    .step_i     (ctrl_i.div_step),
    .dividend_i (acc_q),
    .divisor_i  (b_q),
    .quo_o      (quo),
    .rem_o      (rem),
    .more_o     (div_more)
  );

  // Combinational ALU operations
  always_comb begin
    logic [2*W-1:0]  prod;
    logic [2*W-1:0]  dbl;
    aawf_pkg::word_t x;
    prod      = acc_q * b_q;
    dbl       = '0;
    x         = bm_q ? aawf_pkg::word_t'(acc_q[aawf_pkg::ByteBits-1:0]) : acc_q;
    r_exec    = acc_q;
    f_exec    = flags_q;
    derr_exec = 1'b0;
    unique case (op_q)
      aawf_pkg::OP_ADD: begin
        r_exec = acc_q + b_q;
        f_exec = aawf_pkg::add_rule(r_exec, acc_q, b_q);
      end
      aawf_pkg::OP_SUB: begin
        r_exec       = acc_q - b_q;
        f_exec       = aawf_pkg::zs_flags(r_exec);
        f_exec.carry = acc_q < b_q;
        f_exec.ovf   = acc_q[W-1] ^ b_q[W-1] && acc_q[W-1] ^ r_exec[W-1];
      end
      aawf_pkg::OP_MUL: begin
        r_exec = prod[W-1:0];
        f_exec = aawf_pkg::add_rule(r_exec, acc_q, b_q);
        if (prod[2*W-1:W] != '0) begin
          f_exec.carry = 1'b1;
        end
      end
      // Only reached with a zero divisor
      aawf_pkg::OP_DIV, aawf_pkg::OP_REM: begin
        derr_exec = 1'b1;
      end
      aawf_pkg::OP_AND: begin
        r_exec = acc_q & b_q;
        f_exec = aawf_pkg::add_rule(r_exec, acc_q, b_q);
      end
      aawf_pkg::OP_OR: begin
        r_exec = acc_q | b_q;
        f_exec = aawf_pkg::add_rule(r_exec, acc_q, b_q);
      end
      aawf_pkg::OP_XOR: begin
        r_exec = acc_q ^ b_q;
        f_exec = aawf_pkg::add_rule(r_exec, acc_q, b_q);
      end
      aawf_pkg::OP_NOT: begin
        r_exec = ~acc_q;
        f_exec = aawf_pkg::add_rule(r_exec, acc_q, '0);
      end
      aawf_pkg::OP_SHL: begin
        r_exec = (b_q >= aawf_pkg::word_t'(W)) ? '0 : acc_q << b_q[aawf_pkg::CntBits-1:0];
        f_exec = aawf_pkg::add_rule(r_exec, acc_q, '0);
      end
      aawf_pkg::OP_SHR: begin
        r_exec = (b_q >= aawf_pkg::word_t'(W)) ? '0 : acc_q >> b_q[aawf_pkg::CntBits-1:0];
        f_exec = aawf_pkg::add_rule(r_exec, acc_q, '0);
      end
      aawf_pkg::OP_ROL: begin
        dbl    = {acc_q, acc_q} << b_q[aawf_pkg::CntBits-1:0];
        r_exec = dbl[2*W-1:W];
        f_exec = aawf_pkg::add_rule(r_exec, acc_q, '0);
      end
      aawf_pkg::OP_ROR: begin
        dbl    = {acc_q, acc_q} >> b_q[aawf_pkg::CntBits-1:0];
        r_exec = dbl[W-1:0];
        f_exec = aawf_pkg::add_rule(r_exec, acc_q, '0);
      end
      aawf_pkg::OP_CMP: begin
        if (x < b_q) begin
          r_exec = '1;
        end else if (x == b_q) begin
          r_exec = '0;
        end else begin
          r_exec = aawf_pkg::word_t'(1);
        end
        f_exec = aawf_pkg::zs_flags(r_exec);
      end
      aawf_pkg::OP_LOAD: begin
        r_exec = b_q;
      end
      default: begin
        // unused code: state unchanged
      end
    endcase
  end

  assign r_div = (op_q == aawf_pkg::OP_DIV) ? quo : rem;

  // Accumulator and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      flags_q <= '0;
      derr_q  <= 1'b0;
    end else if (ctrl_i.alu_exec) begin
      acc_q   <= r_exec;
      flags_q <= f_exec;
      derr_q  <= derr_exec;
    end else if (ctrl_i.div_fin) begin
      acc_q   <= r_div;
      flags_q <= aawf_pkg::add_rule(r_div, acc_q, b_q);
      derr_q  <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_acc_q   <= acc_q;
      out_flags_q <= flags_q;
      out_derr_q  <= derr_q;
    end
  end

  assign stat_o.in_valid = in_valid_i;
  assign stat_o.is_div   = is_divop && (b_q != '0);
  assign stat_o.div_more = div_more;
  assign stat_o.out_busy = out_busy;

  assign out_valid_o     = out_valid_q;
  assign acc_out_o       = 16'(out_acc_q);
  assign zero_flag_o     = out_flags_q.zero;
  assign carry_flag_o    = out_flags_q.carry;
  assign sign_flag_o     = out_flags_q.sign;
  assign overflow_flag_o = out_flags_q.ovf;
  assign divide_error_o  = out_derr_q;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // Spare op code with no defined operation
  localparam logic [3:0] OpUnused = 4'd15;

  // Fallback end of run
  localparam longint unsigned RunLimitNs = 64'd20_000_000;

  // Expected result of one item
  typedef struct packed {
    logic [15:0] acc;
    logic        zero;
    logic        carry;
    logic        sign;
    logic        ovf;
    logic        derr;
  } alu_result_t;

  // Shadow flag register
  typedef struct packed {
    logic ovf;
    logic sign;
    logic carry;
    logic zero;
  } alu_flags_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  op_i = 4'd0;
  logic [15:0] operand_i = 16'd0;
  logic        byte_mode_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] acc_out_o;
  logic        zero_flag_o;
  logic        carry_flag_o;
  logic        sign_flag_o;
  logic        overflow_flag_o;
  logic        divide_error_o;

  // Shadow copy of the accumulator state
  logic [15:0] acc_shadow = 16'd0;
  alu_flags_t  flags_shadow = '0;

  alu_result_t pending_results[$];
  int unsigned mismatch_count = 0;
  bit          steady = 1'b0;  // no idling on either side when set

  accumulator_alu_with_flags_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .operand_i      (operand_i),
    .byte_mode_i    (byte_mode_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .acc_out_o      (acc_out_o),
    .zero_flag_o    (zero_flag_o),
    .carry_flag_o   (carry_flag_o),
    .sign_flag_o    (sign_flag_o),
    .overflow_flag_o(overflow_flag_o),
    .divide_error_o (divide_error_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Zero/sign from result, carry/overflow by the add rule
  function automatic alu_flags_t add_style_flags(logic [15:0] r, logic [15:0] a,
                                                 logic [15:0] b);
    alu_flags_t f;
    logic [15:0] t;
    t       = (a ^ r) & (b ^ r);
    f.zero  = (r == 16'd0);
    f.sign  = r[15];
    f.carry = (r < a) || (r < b);
    f.ovf   = t[15];
    return f;
  endfunction

  // Apply one item to the shadow state and return what the block should show
  function automatic alu_result_t alu_predict(logic [3:0] op, logic [15:0] opnd,
                                              logic bm);
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] r;
    logic [15:0] x;
    logic [31:0] p;
    logic [3:0]  k;
    logic        derr;
    alu_flags_t  f;
    alu_result_t res;
    a    = acc_shadow;
    b    = bm ? {8'h00, opnd[7:0]} : opnd;
    r    = a;
    f    = flags_shadow;
    derr = 1'b0;
    k    = b[3:0];
    case (op)
      aawf_pkg::OP_ADD: begin
        r = a + b;
        f = add_style_flags(r, a, b);
      end
      aawf_pkg::OP_SUB: begin
        x       = (a ^ b) & (a ^ r);
        r       = a - b;
        x       = (a ^ b) & (a ^ r);
        f       = '0;
        f.zero  = (r == 16'd0);
        f.sign  = r[15];
        f.carry = (a < b);
        f.ovf   = x[15];
      end
      aawf_pkg::OP_MUL: begin
        p = 32'(a) * 32'(b);
        r = p[15:0];
        f = add_style_flags(r, a, b);
        if (p[31:16] != 16'd0) f.carry = 1'b1;
      end
      aawf_pkg::OP_DIV, aawf_pkg::OP_REM: begin
        if (b == 16'd0) begin
          derr = 1'b1;
        end else begin
          r = (op == aawf_pkg::OP_DIV) ? (a / b) : (a % b);
          f = add_style_flags(r, a, b);
        end
      end
      aawf_pkg::OP_AND: begin
        r = a & b;
        f = add_style_flags(r, a, b);
      end
      aawf_pkg::OP_OR: begin
        r = a | b;
        f = add_style_flags(r, a, b);
      end
      aawf_pkg::OP_XOR: begin
        r = a ^ b;
        f = add_style_flags(r, a, b);
      end
      aawf_pkg::OP_NOT: begin
        r = ~a;
        f = add_style_flags(r, a, 16'd0);
      end
      aawf_pkg::OP_SHL: begin
        r = (b >= 16) ? 16'd0 : (a << b);
        f = add_style_flags(r, a, 16'd0);
      end
      aawf_pkg::OP_SHR: begin
        r = (b >= 16) ? 16'd0 : (a >> b);
        f = add_style_flags(r, a, 16'd0);
      end
      aawf_pkg::OP_ROL: begin
        r = (k == 4'd0) ? a : ((a << k) | (a >> (16 - k)));
        f = add_style_flags(r, a, 16'd0);
      end
      aawf_pkg::OP_ROR: begin
        r = (k == 4'd0) ? a : ((a >> k) | (a << (16 - k)));
        f = add_style_flags(r, a, 16'd0);
      end
      aawf_pkg::OP_CMP: begin
        // byte mode compares low bytes only
        x = bm ? {8'h00, a[7:0]} : a;
        if (x < b) r = 16'hFFFF;
        else if (x == b) r = 16'd0;
        else r = 16'd1;
        f      = '0;
        f.zero = (r == 16'd0);
        f.sign = r[15];
      end
      aawf_pkg::OP_LOAD: begin
        r = b;  // flags kept
      end
      default: begin
      end
    endcase
    acc_shadow   = r;
    flags_shadow = f;
    res.acc   = r;
    res.zero  = f.zero;
    res.carry = f.carry;
    res.sign  = f.sign;
    res.ovf   = f.ovf;
    res.derr  = derr;
    return res;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Operand biased toward corner values and small counts
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      3: return 16'h0001;
      4, 5: return 16'($urandom_range(0, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  // Any op code, the spare one now and then
  function automatic logic [3:0] pick_op();
    if ($urandom_range(0, 49) == 0) return OpUnused;
    return 4'($urandom_range(0, 14));
  endfunction

  // Drive one item and record its expected result once accepted
  task automatic send_item(input logic [3:0] op, input logic [15:0] opnd, input logic bm);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    op_i        <= op;
    operand_i   <= opnd;
    byte_mode_i <= bm;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(alu_predict(op, opnd, bm));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_item(pick_op(), pick_operand(), 1'($urandom_range(0, 1)));
    end
  endtask

  // Corners of each operation and the listed special cases
  task automatic test_directed();
    send_item(aawf_pkg::OP_LOAD, 16'hFFFF, 1'b0);
    send_item(aawf_pkg::OP_ADD, 16'h0001, 1'b0);   // wrap to zero with carry
    send_item(aawf_pkg::OP_LOAD, 16'h7FFF, 1'b0);
    send_item(aawf_pkg::OP_ADD, 16'h0001, 1'b0);   // signed overflow
    send_item(aawf_pkg::OP_SUB, 16'h0001, 1'b0);   // overflow on subtract
    send_item(aawf_pkg::OP_LOAD, 16'h0000, 1'b0);
    send_item(aawf_pkg::OP_SUB, 16'h0001, 1'b0);   // borrow
    send_item(aawf_pkg::OP_MUL, 16'hFFFF, 1'b0);   // wide product
    send_item(aawf_pkg::OP_DIV, 16'h0000, 1'b0);   // divide by zero
    send_item(aawf_pkg::OP_REM, 16'h0100, 1'b1);   // zero once byte-masked
    send_item(aawf_pkg::OP_LOAD, 16'h1234, 1'b0);
    send_item(aawf_pkg::OP_DIV, 16'h0007, 1'b0);
    send_item(aawf_pkg::OP_REM, 16'h0005, 1'b0);
    send_item(aawf_pkg::OP_OR, 16'hF0F0, 1'b0);
    send_item(aawf_pkg::OP_AND, 16'h0F0F, 1'b0);
    send_item(aawf_pkg::OP_XOR, 16'hFFFF, 1'b1);
    send_item(aawf_pkg::OP_NOT, 16'hFFFF, 1'b1);   // byte mode has no effect
    send_item(aawf_pkg::OP_SHL, 16'h0010, 1'b0);   // count of 16 clears
    send_item(aawf_pkg::OP_LOAD, 16'h8001, 1'b0);
    send_item(aawf_pkg::OP_ROL, 16'h0011, 1'b0);   // count taken mod 16
    send_item(aawf_pkg::OP_ROR, 16'h0010, 1'b0);
    send_item(aawf_pkg::OP_SHR, 16'hFFFF, 1'b0);
    send_item(aawf_pkg::OP_LOAD, 16'h1280, 1'b0);
    send_item(aawf_pkg::OP_CMP, 16'h1281, 1'b1);   // low byte 0x80 below masked 0x81
    send_item(OpUnused, 16'hFFFF, 1'b1);
    wait_results_drained();
  endtask

  // Fully random items with idling on both sides
  task automatic test_random_mix();
    send_random(450);
  endtask

  // Back-to-back items, neither side idles
  task automatic test_streaming();
    steady = 1'b1;
    send_random(200);
    wait_results_drained();
    steady = 1'b0;
  endtask

  // Long divider path, zero divisors among them
  task automatic test_divide();
    for (int unsigned i = 0; i < 200; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_item(aawf_pkg::OP_LOAD, 16'($urandom), 1'b0);
      else
        send_item(($urandom_range(0, 1) != 0) ? aawf_pkg::OP_DIV : aawf_pkg::OP_REM,
                  pick_operand(), 1'($urandom_range(0, 1)));
    end
  endtask

  // Shifts and rotates over the whole count range
  task automatic test_shift_rotate();
    for (int unsigned i = 0; i < 150; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_item(aawf_pkg::OP_LOAD, 16'($urandom), 1'b0);
      else
        send_item(4'($urandom_range(aawf_pkg::OP_SHL, aawf_pkg::OP_ROR)), pick_operand(),
                  1'($urandom_range(0, 1)));
    end
  endtask

  // Compare against operands chosen from each load to hit less, equal and greater in both modes
  task automatic test_compare();
    logic [15:0] val;
    for (int unsigned i = 0; i < 75; i++) begin
      val = 16'($urandom);
      send_item(aawf_pkg::OP_LOAD, val, 1'b0);
      case ($urandom_range(0, 2))
        0: send_item(aawf_pkg::OP_CMP, val, 1'($urandom_range(0, 1)));
        1: send_item(aawf_pkg::OP_CMP, val + 16'($urandom_range(0, 2)),
                     1'($urandom_range(0, 1)));
        default: send_item(aawf_pkg::OP_CMP, pick_operand(), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  // Sender holds off until the block has delivered everything
  task automatic test_drain_pause();
    for (int unsigned i = 0; i < 10; i++) begin
      send_random(10);
      wait_results_drained();
    end
  endtask

  // Receiver side: ready drops for random stretches
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (!steady && hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] exp_val,
                                      logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin : result_check
    alu_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result acc_out=0x%0h with no item outstanding", acc_out_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("acc_out", want.acc, acc_out_o);
        check_field("zero_flag", 16'(want.zero), 16'(zero_flag_o));
        check_field("carry_flag", 16'(want.carry), 16'(carry_flag_o));
        check_field("sign_flag", 16'(want.sign), 16'(sign_flag_o));
        check_field("overflow_flag", 16'(want.ovf), 16'(overflow_flag_o));
        check_field("divide_error", 16'(want.derr), 16'(divide_error_o));
      end
    end
  end

  // Hang guard
  initial begin
    #(RunLimitNs);
    $display("FAIL accumulator_alu_with_flags_core");
    $finish;
  end

  // Test sequence
  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_mix();
    test_streaming();
    test_divide();
    test_shift_rotate();
    test_compare();
    test_drain_pause();
    wait_results_drained();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS accumulator_alu_with_flags_core");
    end else begin
      $display("FAIL accumulator_alu_with_flags_core");
    end
    $finish;
  end

endmodule
